// ===== rtl/epv_pkg.sv =====
`timescale 1ns / 1ps
// epv_pkg: widths, scale constants, handshake structs and the saturation helper
// shared by the encoder position/velocity block and its serial arithmetic units.
// No dependencies.
package epv_pkg;

   localparam int SAMPLE_W = 16;   // encoder counter sample
   localparam int DT_W     = 20;   // elapsed time, microseconds
   localparam int CPT_W    = 15;   // counts per turn register
   localparam int OUT_W    = 32;   // result fields

   localparam int DIV_W    = 50;   // dividend / quotient shift register
   localparam int DEN_W    = 20;   // divisor width (max of CPT_W, DT_W)
   localparam int CNT_W    = 6;    // holds bit counts up to DIV_W
   localparam int MUL_W    = 50;   // product width
   localparam int CONST_W  = 29;   // widest scale constant

   localparam logic [CPT_W-1:0] CPT_RESET = CPT_W'(8192);

   // scale constants: degrees per turn, 2*pi*65536, 360e6 (us -> s)
   localparam logic [CONST_W-1:0] DEG_K = CONST_W'(360);
   localparam logic [CONST_W-1:0] RAD_K = CONST_W'(411775);
   localparam logic [CONST_W-1:0] SPD_K = CONST_W'(360000000);
   localparam int                 RAD_SHIFT = 16;

   // quotient bit counts, sized to the largest dividend magnitude of each op
   localparam logic [CNT_W-1:0] TURN_BITS = CNT_W'(32);
   localparam logic [CNT_W-1:0] DEG_BITS  = CNT_W'(40);
   localparam logic [CNT_W-1:0] RAD_BITS  = CNT_W'(34);
   localparam logic [CNT_W-1:0] SPD_BITS  = CNT_W'(44);

   localparam logic [DIV_W-1:0] NEG_LIMIT = DIV_W'(64'h8000_0000);
   localparam logic [DIV_W-1:0] POS_LIMIT = DIV_W'(64'h7FFF_FFFF);

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] nbits;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   // apply sign to an unsigned magnitude and clamp to the 32-bit signed range
   function automatic logic [OUT_W-1:0] sat_mag(input logic neg, input logic [DIV_W-1:0] mag);
      logic [OUT_W-1:0] r;
      if (neg) begin
         if (mag > NEG_LIMIT) r = 32'h8000_0000;
         else                 r = ~mag[OUT_W-1:0] + 32'd1;
      end else begin
         if (mag > POS_LIMIT) r = 32'h7FFF_FFFF;
         else                 r = mag[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/encoder_position_velocity.sv =====
`timescale 1ns / 1ps
// encoder_position_velocity: extends a 16-bit encoder counter to a 32-bit count and
// derives turns, degrees, radians and speed. Depends on epv_pkg, epv_mul, epv_div.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_counter_value, req_dt_us
//   rsp      out  rsp_valid/rsp_ready    rsp_total_count .. rsp_speed_deg_per_s
//   csr      in   csr_wr_en              csr_wr_data (counts per turn)
//
// One beat at a time, computed by the shared serial divider
// (194 quotient bits over five divisions) and the serial multiplier (57 constant bits).
// req_ready is high only in idle; the next beat is taken while a result still waits.
// A stalled result holds the block in its final state until rsp_ready.
// Synchronous reset clears the count, the last sample and sets counts per turn to 8192.
module encoder_position_velocity (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [epv_pkg::CPT_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [epv_pkg::SAMPLE_W-1:0]      req_counter_value,
   input  logic [epv_pkg::DT_W-1:0]          req_dt_us,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [epv_pkg::OUT_W-1:0]  rsp_total_count,
   output logic signed [epv_pkg::OUT_W-1:0]  rsp_whole_turns,
   output logic signed [epv_pkg::OUT_W-1:0]  rsp_angle_degrees,
   output logic signed [epv_pkg::OUT_W-1:0]  rsp_angle_radians,
   output logic signed [epv_pkg::OUT_W-1:0]  rsp_speed_deg_per_s
);
   import epv_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TURNS,
      ST_DEG_MUL,
      ST_DEG_DIV,
      ST_RAD_MUL,
      ST_RAD_DIV,
      ST_SPD_MUL,
      ST_SPD_DIV1,
      ST_SPD_DIV2,
      ST_FINISH
   } state_type;

   state_type            state_ff;
   logic                 go_ff;
   logic [CPT_W-1:0]     cpt_cfg_ff;
   logic [SAMPLE_W-1:0]  last_ff;
   logic [OUT_W-1:0]     count_ff;
   logic [SAMPLE_W-1:0]  diff_ff;
   logic [DT_W-1:0]      dt_ff;
   logic [CPT_W-1:0]     cpt_ff;
   logic [OUT_W-1:0]     turns_ff;
   logic [OUT_W-1:0]     deg_ff;
   logic [OUT_W-1:0]     rad_ff;
   logic [OUT_W-1:0]     spd_ff;
   logic                 rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_total_ff;
   logic signed [OUT_W-1:0] rsp_turns_ff;
   logic signed [OUT_W-1:0] rsp_deg_ff;
   logic signed [OUT_W-1:0] rsp_rad_ff;
   logic signed [OUT_W-1:0] rsp_speed_ff;

   logic [SAMPLE_W-1:0]  diff_in;
   logic [OUT_W-1:0]     count_in;
   logic [OUT_W-1:0]     abs_count;
   logic [SAMPLE_W-1:0]  abs_diff;

   div_cmd_type          div_cmd;
   unit_sts_type         div_sts;
   logic [DIV_W-1:0]     div_dividend;
   logic [DEN_W-1:0]     div_divisor;
   logic [DIV_W-1:0]     div_q;

   logic                 mul_start;
   unit_sts_type         mul_sts;
   logic [OUT_W-1:0]     mul_a;
   logic [CONST_W-1:0]   mul_k;
   logic [MUL_W-1:0]     mul_p;

   // counter difference wraps at the sample width
   assign diff_in   = req_counter_value - last_ff;
   assign count_in  = count_ff + {{(OUT_W-SAMPLE_W){diff_in[SAMPLE_W-1]}}, diff_in};
   assign abs_count = count_ff[OUT_W-1] ? (~count_ff + 1'b1) : count_ff;
   assign abs_diff  = diff_ff[SAMPLE_W-1] ? (~diff_ff + 1'b1) : diff_ff;

   always_comb begin
      div_dividend = mul_p;
      div_divisor  = DEN_W'(cpt_ff);
      div_cmd.nbits = SPD_BITS;
      case (state_ff)
         ST_TURNS: begin
            div_dividend  = DIV_W'(abs_count);
            div_cmd.nbits = TURN_BITS;
         end
         ST_DEG_DIV: begin
            div_cmd.nbits = DEG_BITS;
         end
         ST_RAD_DIV: begin
            // divide by cpt << 16 as a shift then a divide by cpt
            div_dividend  = mul_p >> RAD_SHIFT;
            div_cmd.nbits = RAD_BITS;
         end
         ST_SPD_DIV2: begin
            div_dividend = div_q;
            div_divisor  = dt_ff;
         end
         default: begin
         end
      endcase
      div_cmd.start = go_ff && (state_ff inside {ST_TURNS, ST_DEG_DIV, ST_RAD_DIV,
                                                 ST_SPD_DIV1, ST_SPD_DIV2});
   end

   always_comb begin
      mul_a = abs_count;
      mul_k = DEG_K;
      case (state_ff)
         ST_RAD_MUL: mul_k = RAD_K;
         ST_SPD_MUL: begin
            mul_a = OUT_W'(abs_diff);
            mul_k = SPD_K;
         end
         default: begin
         end
      endcase
      mul_start = go_ff && (state_ff inside {ST_DEG_MUL, ST_RAD_MUL, ST_SPD_MUL});
   end

   epv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_q)
   );

   epv_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_a),
      .multiplier   (mul_k),
      .sts          (mul_sts),
      .product      (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cpt_cfg_ff   <= CPT_RESET;
         last_ff      <= '0;
         count_ff     <= '0;
      end else begin
         go_ff <= 1'b0;
         if (csr_wr_en) cpt_cfg_ff <= csr_wr_data;
         // in the final state the valid flag is owned by the load below
         if (rsp_ready && (state_ff != ST_FINISH)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  last_ff  <= req_counter_value;
                  count_ff <= count_in;
                  diff_ff  <= diff_in;
                  dt_ff    <= (req_dt_us == '0) ? DT_W'(1) : req_dt_us;
                  cpt_ff   <= (cpt_cfg_ff == '0) ? CPT_W'(1) : cpt_cfg_ff;
                  state_ff <= ST_TURNS;
                  go_ff    <= 1'b1;
               end
            end
            ST_TURNS: begin
               if (div_sts.done) begin
                  turns_ff <= sat_mag(count_ff[OUT_W-1], div_q);
                  state_ff <= ST_DEG_MUL;
                  go_ff    <= 1'b1;
               end
            end
            ST_DEG_MUL: begin
               if (mul_sts.done) begin
                  state_ff <= ST_DEG_DIV;
                  go_ff    <= 1'b1;
               end
            end
            ST_DEG_DIV: begin
               if (div_sts.done) begin
                  deg_ff   <= sat_mag(count_ff[OUT_W-1], div_q);
                  state_ff <= ST_RAD_MUL;
                  go_ff    <= 1'b1;
               end
            end
            ST_RAD_MUL: begin
               if (mul_sts.done) begin
                  state_ff <= ST_RAD_DIV;
                  go_ff    <= 1'b1;
               end
            end
            ST_RAD_DIV: begin
               if (div_sts.done) begin
                  rad_ff   <= sat_mag(count_ff[OUT_W-1], div_q);
                  state_ff <= ST_SPD_MUL;
                  go_ff    <= 1'b1;
               end
            end
            ST_SPD_MUL: begin
               if (mul_sts.done) begin
                  state_ff <= ST_SPD_DIV1;
                  go_ff    <= 1'b1;
               end
            end
            ST_SPD_DIV1: begin
               // divide by cpt, then by dt: same truncation as one divide by cpt*dt
               if (div_sts.done) begin
                  state_ff <= ST_SPD_DIV2;
                  go_ff    <= 1'b1;
               end
            end
            ST_SPD_DIV2: begin
               if (div_sts.done) begin
                  spd_ff   <= sat_mag(diff_ff[SAMPLE_W-1], div_q);
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_total_ff <= $signed(count_ff);
                  rsp_turns_ff <= $signed(turns_ff);
                  rsp_deg_ff   <= $signed(deg_ff);
                  rsp_rad_ff   <= $signed(rad_ff);
                  rsp_speed_ff <= $signed(spd_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_total_count     = rsp_total_ff;
   assign rsp_whole_turns     = rsp_turns_ff;
   assign rsp_angle_degrees   = rsp_deg_ff;
   assign rsp_angle_radians   = rsp_rad_ff;
   assign rsp_speed_deg_per_s = rsp_speed_ff;

`ifndef SYNTHESIS
   a_one_beat_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input beat taken while another is in progress");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_sts.done && mul_sts.done))
      else $error("divider and multiplier finished together");

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(div_sts.busy || mul_sts.busy))
      else $error("arithmetic unit busy while idle");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FINISH))
      else $error("result overwrote a pending beat");
`endif

endmodule

// ===== rtl/epv_mul.sv =====
`timescale 1ns / 1ps
// epv_mul: serial shift-add multiplier, one constant bit per cycle, LSB first.
// Depends on epv_pkg.
module epv_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [epv_pkg::OUT_W-1:0]    multiplicand,
   input  logic [epv_pkg::CONST_W-1:0]  multiplier,
   output epv_pkg::unit_sts_type        sts,
   output logic [epv_pkg::MUL_W-1:0]    product
);
   import epv_pkg::*;

   logic               busy_ff;
   logic               done_ff;
   logic [MUL_W-1:0]   acc_ff;
   logic [MUL_W-1:0]   mcand_ff;
   logic [CONST_W-1:0] mult_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (mult_ff[CONST_W-1:1] == '0)) begin
            // last set bit consumed
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff   <= '0;
         mcand_ff <= MUL_W'(multiplicand);
         mult_ff  <= multiplier;
      end else if (busy_ff) begin
         if (mult_ff[0]) acc_ff <= acc_ff + mcand_ff;
         mcand_ff <= mcand_ff << 1;
         mult_ff  <= mult_ff >> 1;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = acc_ff;

endmodule

// ===== rtl/epv_div.sv =====
`timescale 1ns / 1ps
// epv_div: restoring radix-2 divider, unsigned, one quotient bit per cycle.
// Depends on epv_pkg.
module epv_div (
   input  logic                        clock,
   input  logic                        reset,
   input  epv_pkg::div_cmd_type        cmd,
   input  logic [epv_pkg::DIV_W-1:0]   dividend,
   input  logic [epv_pkg::DEN_W-1:0]   divisor,
   output epv_pkg::unit_sts_type       sts,
   output logic [epv_pkg::DIV_W-1:0]   quotient
);
   import epv_pkg::*;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DIV_W-1:0] q_ff;

   logic [DEN_W:0]   rem_shift;
   logic             fits;
   logic [DEN_W-1:0] rem_in;

   assign rem_shift = {rem_ff, q_ff[DIV_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   // remainder stays below the divisor, so it fits back into DEN_W bits
   assign rem_in    = fits ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.nbits;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend is left-aligned so only nbits steps are needed; the zeros shifted
   // in below it leave the quotient alone in q_ff at the end
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= '0;
         den_ff <= divisor;
         q_ff   <= dividend << (CNT_W'(DIV_W) - cmd.nbits);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[DIV_W-2:0], fits};
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = q_ff;

endmodule

// ===== sim/tb_encoder_position_velocity.sv =====
`timescale 1ns / 1ps
// tb_encoder_position_velocity: self-checking bench for encoder_position_velocity.
// Sends directed and random counter samples, computes the expected position and speed
// here, and checks every result beat in order. Depends on epv_pkg and the block's RTL.
module tb_encoder_position_velocity;
   import epv_pkg::*;

   typedef struct {
      logic signed [OUT_W-1:0] count;
      logic signed [OUT_W-1:0] turns;
      logic signed [OUT_W-1:0] degrees;
      logic signed [OUT_W-1:0] radians;
      logic signed [OUT_W-1:0] speed;
   } position_type;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [DT_W-1:0]     DT_MAX     = '1;
   localparam logic [CPT_W-1:0]    CPT_MAX    = '1;
   localparam int                  MAX_REPORTS = 40;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CPT_W-1:0]        csr_wr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [SAMPLE_W-1:0]     req_counter_value = '0;
   logic [DT_W-1:0]         req_dt_us = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_total_count;
   logic signed [OUT_W-1:0] rsp_whole_turns;
   logic signed [OUT_W-1:0] rsp_angle_degrees;
   logic signed [OUT_W-1:0] rsp_angle_radians;
   logic signed [OUT_W-1:0] rsp_speed_deg_per_s;

   // predictor state, mirrors the block after reset
   logic [SAMPLE_W-1:0] model_last_sample = '0;
   logic [OUT_W-1:0]    model_count = '0;
   logic [CPT_W-1:0]    model_cpt = CPT_RESET;

   position_type pending_positions[$];
   int        mismatches = 0;
   int        results_seen = 0;
   int        samples_sent = 0;
   int        cpt_settings = 0;
   bit        gaps_on = 1'b0;
   int        rsp_stall_left = 0;

   encoder_position_velocity i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_counter_value   (req_counter_value),
      .req_dt_us           (req_dt_us),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_count     (rsp_total_count),
      .rsp_whole_turns     (rsp_whole_turns),
      .rsp_angle_degrees   (rsp_angle_degrees),
      .rsp_angle_radians   (rsp_angle_radians),
      .rsp_speed_deg_per_s (rsp_speed_deg_per_s)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic signed [OUT_W-1:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[OUT_W-1:0];
   endfunction

   // extends the sample into the running count, then derives turns, angles and speed
   function automatic position_type advance_position(input logic [SAMPLE_W-1:0] sample,
                                                     input logic [DT_W-1:0] dt_in);
      logic [SAMPLE_W-1:0] delta;
      longint cpt, dt, diff, count, deg_k, rad_k, spd_k;
      position_type p;
      deg_k = DEG_K;
      rad_k = RAD_K;
      spd_k = SPD_K;
      cpt = model_cpt;
      if (cpt == 0) cpt = 1;
      dt = dt_in;
      if (dt == 0) dt = 1;
      delta = sample - model_last_sample;
      diff = $signed(delta);
      model_last_sample = sample;
      model_count = model_count + diff[OUT_W-1:0];
      count = $signed(model_count);
      p.count   = model_count;
      p.turns   = clamp32(count / cpt);
      p.degrees = clamp32((count * deg_k) / cpt);
      p.radians = clamp32((count * rad_k) / (cpt <<< RAD_SHIFT));
      p.speed   = clamp32((diff * spd_k) / (cpt * dt));
      return p;
   endfunction

   function automatic logic [DT_W-1:0] random_dt();
      case ($urandom_range(0, 3))
         0:       return DT_W'($urandom_range(0, 3));
         1:       return DT_W'($urandom_range(0, DT_MAX));
         default: return DT_W'($urandom_range(100, 10000));
      endcase
   endfunction

   // mostly plausible motion from the last sample, sometimes an arbitrary jump
   function automatic logic [SAMPLE_W-1:0] random_sample(input int unsigned max_step);
      logic [SAMPLE_W-1:0] step;
      if ($urandom_range(0, 3) == 0) return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      step = SAMPLE_W'($urandom_range(0, max_step));
      if ($urandom_range(0, 1) == 0) return model_last_sample + step;
      return model_last_sample - step;
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic [DT_W-1:0] dt_in);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         // sometimes line the gap up with the result phase
         if ($urandom_range(0, 1) == 0)
            while (pending_positions.size() != 0 && !rsp_valid) @(posedge clock);
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_counter_value <= sample;
      req_dt_us         <= dt_in;
      do @(posedge clock); while (!req_ready);
      pending_positions.push_back(advance_position(sample, dt_in));
      samples_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_positions.size() != 0);
   endtask

   task automatic write_counts_per_turn(input logic [CPT_W-1:0] value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_cpt = value;
      cpt_settings++;
   endtask

   task automatic compare_field(input string label, input logic signed [OUT_W-1:0] want,
                                input logic signed [OUT_W-1:0] got);
      if (got !== want) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   task automatic check_position();
      position_type want;
      if (pending_positions.size() == 0) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t: result beat with nothing pending, total_count actual %0d",
                     $time, rsp_total_count);
         mismatches++;
      end else begin
         want = pending_positions.pop_front();
         results_seen++;
         compare_field("total_count", want.count, rsp_total_count);
         compare_field("whole_turns", want.turns, rsp_whole_turns);
         compare_field("angle_degrees", want.degrees, rsp_angle_degrees);
         compare_field("angle_radians", want.radians, rsp_angle_radians);
         compare_field("speed_deg_per_s", want.speed, rsp_speed_deg_per_s);
      end
   endtask

   // result side: check accepted beats, stall ready in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_position();
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall_left = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // reset value of counts per turn; extreme steps in both directions and odd dt values
   task automatic test_reset_setting_extremes();
      send_sample(16'h0000, 20'd1);
      send_sample(16'h7FFF, 20'd1);
      send_sample(16'hFFFF, 20'd0);
      send_sample(16'h0000, DT_MAX);
      send_sample(16'h8000, DT_MAX);
      send_sample(16'h7FFF, 20'd1000);
   endtask

   // zero counts per turn acts as one; speed saturates both ways
   task automatic test_counts_per_turn_extremes();
      write_counts_per_turn('0);
      send_sample(16'hFFFF, 20'd1);
      send_sample(16'h7FFE, 20'd0);
      send_sample(16'hFFFE, 20'd1);
      write_counts_per_turn(15'd1);
      send_sample(16'h7FFD, 20'd1);
      send_sample(16'h7FFD, DT_MAX);
      send_sample(16'hFFFD, 20'd2);
      write_counts_per_turn(CPT_MAX);
      send_sample(16'h7FFC, 20'd1);
      send_sample(16'h0000, 20'd0);
      send_sample(16'h8000, DT_MAX);
      write_counts_per_turn(15'd360);
      send_sample(16'h1234, 20'd500);
      send_sample(16'hEDCB, 20'd3);
   endtask

   task automatic test_random_motion(input logic [CPT_W-1:0] cpt, input int n_samples);
      write_counts_per_turn(cpt);
      repeat (n_samples) send_sample(random_sample($urandom_range(0, 3) == 0 ? 32767 : 400),
                                     random_dt());
   endtask

   // long forward run, then a tiny counts per turn so the angle saturates
   task automatic test_spin_up();
      write_counts_per_turn(CPT_W'($urandom_range(0, CPT_MAX)));
      repeat (190) send_sample(model_last_sample + SAMPLE_W'($urandom_range(31500, 32767)),
                               random_dt());
      write_counts_per_turn('0);
      repeat (10) send_sample(random_sample(50), random_dt());
   endtask

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_setting_extremes();
      test_counts_per_turn_extremes();
      gaps_on = 1'b1;
      test_random_motion(CPT_W'($urandom_range(0, CPT_MAX)), 60);
      test_spin_up();
      test_random_motion(CPT_MAX, 30);
      test_random_motion(15'd1, 30);
      test_random_motion(CPT_W'($urandom_range(1, 64)), 30);
      test_random_motion(CPT_W'($urandom_range(0, CPT_MAX)), 30);
      gaps_on = 1'b0;
      test_random_motion(CPT_W'($urandom_range(0, CPT_MAX)), 60);
      wait_for_results();
      repeat (300) @(posedge clock);
      $display("Covered %0d samples and %0d checked results over %0d counts-per-turn values,",
               samples_sent, results_seen, cpt_settings);
      $display("including step extremes, zero dt and counts, saturation; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
